/* rtl/core/tsla_pkg.sv */
// Shared constants, command and status types for the template score lane accumulator.
// No dependencies.
`timescale 1ns / 1ps

package tsla_pkg;

    localparam int LANE_COUNT   = 64;
    localparam int WEIGHT_BITS  = 8;
    localparam int MAX_LANES    = 64;
    localparam int GROUP_LANES  = 8;
    localparam int BYTE_BITS    = 8;
    localparam int SUM_BITS     = 32;
    localparam int WEIGHT_IN_W  = 8;
    localparam int LANE_IDX_W   = $clog2(LANE_COUNT);
    localparam int LANE_PORT_W  = 6;
    localparam int RESP_FLAT_W  = BYTE_BITS * MAX_LANES;

    localparam logic [SUM_BITS-1:0] WEIGHT_MASK = SUM_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [LANE_IDX_W-1:0] LAST_LANE_IDX = LANE_IDX_W'(LANE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_ACCUM = 3'b001,
        ST_SCORE = 3'b010,
        ST_EMIT  = 3'b100
    } tsla_state_t;

    typedef struct packed {
        logic acc_en;
        logic score_en;
        logic shift_en;
    } tsla_cmd_t;

    typedef struct packed {
        logic last_lane;
    } tsla_sts_t;

endpackage

/* rtl/core/tsla_datapath.sv */
// Lane datapath: 64 multiply-accumulate lanes, threshold register, valid mask and
// result shift line. Depends on tsla_pkg.
`timescale 1ns / 1ps

module tsla_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tsla_pkg::tsla_cmd_t               cmd,
    output tsla_pkg::tsla_sts_t               sts,
    input  logic                              cfg_wr_en,
    input  logic [tsla_pkg::SUM_BITS-1:0]     cfg_wr_data,
    input  logic [tsla_pkg::RESP_FLAT_W-1:0]  resp_flat,
    input  logic [tsla_pkg::WEIGHT_IN_W-1:0]  point_weight,
    output logic [tsla_pkg::LANE_PORT_W-1:0]  lane_index,
    output logic [tsla_pkg::SUM_BITS-1:0]     raw_cost,
    output logic                              lane_valid,
    output logic [tsla_pkg::MAX_LANES-1:0]    valid_mask,
    output logic                              last_lane
);
    import tsla_pkg::*;

    logic [SUM_BITS-1:0]   sums_reg  [LANE_COUNT];
    logic [SUM_BITS-1:0]   sums_next [LANE_COUNT];
    logic [LANE_COUNT-1:0] mask_reg;
    logic [LANE_COUNT-1:0] mask_next;
    logic [LANE_IDX_W-1:0] cnt_reg;
    logic [LANE_IDX_W-1:0] cnt_next;
    logic [SUM_BITS-1:0]   thresh_reg;
    logic [SUM_BITS-1:0]   weight;

    assign weight = SUM_BITS'(point_weight) & WEIGHT_MASK;

    always_comb
    begin
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            sums_next[i] = sums_reg[i];
            mask_next[i] = mask_reg[i];
            if (cmd.acc_en)
            begin
                sums_next[i] = sums_reg[i]
                    + SUM_BITS'(SUM_BITS'(resp_flat[BYTE_BITS*i +: BYTE_BITS]) * weight);
            end
            else if (cmd.shift_en)
            begin
                sums_next[i] = (i == LANE_COUNT - 1) ? '0 : sums_reg[(i + 1) % LANE_COUNT];
            end
            if (cmd.score_en)
            begin
                mask_next[i] = (sums_reg[i] <= thresh_reg);
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.shift_en)
        begin
            cnt_next = (cnt_reg == LAST_LANE_IDX) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                sums_reg[i] <= '0;
            end
            mask_reg   <= '0;
            cnt_reg    <= '0;
            thresh_reg <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
            mask_reg <= mask_next;
            cnt_reg  <= cnt_next;
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    assign sts.last_lane = (cnt_reg == LAST_LANE_IDX);
    assign lane_index    = LANE_PORT_W'(cnt_reg);
    assign raw_cost      = sums_reg[0];
    assign lane_valid    = mask_reg[cnt_reg];
    assign valid_mask    = MAX_LANES'(mask_reg);
    assign last_lane     = sts.last_lane;

endmodule

/* rtl/core/tsla_ctrl.sv */
// Controller state machine: accumulate, score, emit sequencing.
// Depends on tsla_pkg; drives tsla_datapath through command and status structs.
`timescale 1ns / 1ps

module tsla_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_point,
    input  logic                 out_ready,
    input  tsla_pkg::tsla_sts_t  sts,
    output tsla_pkg::tsla_cmd_t  cmd,
    output logic                 in_ready,
    output logic                 out_valid
);
    import tsla_pkg::*;

    tsla_state_t state_reg;
    tsla_state_t state_next;
    logic        in_xact;
    logic        out_xact;

    assign in_ready  = (state_reg == ST_ACCUM);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_xact   = in_valid && in_ready;
    assign out_xact  = out_valid && out_ready;

    assign cmd.acc_en   = in_xact;
    assign cmd.score_en = (state_reg == ST_SCORE);
    assign cmd.shift_en = out_xact;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (in_xact && last_point)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_xact && sts.last_lane)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_score_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCORE) |=> out_valid)
        else $error("score not followed by emit");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xact && !sts.last_lane) |=> out_valid)
        else $error("run ended before last lane");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xact && sts.last_lane) |=> in_ready)
        else $error("run did not end after last lane");

endmodule

/* rtl/core/template_score_lane_accumulator_top.sv */
// Top level of the template score lane accumulator.
// Depends on tsla_pkg, tsla_ctrl and tsla_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): one template point per transaction, carrying
//   the response bytes of all 64 lanes, the point weight and last_point. While a view
//   is accumulating, in_ready is high and one point is taken each cycle in_valid is
//   high; all lanes multiply and accumulate in parallel in the lane datapath.
//   After the point marked last_point, in_ready drops. A score state compares every lane
//   sum against cost_threshold, then the output channel (out_valid/out_ready) presents
//   the 64 lane results in lane order, one per cycle while out_ready is high; last_lane
//   marks lane 63. The result register holds while the receiver stalls.
//   After the last point is taken, the controller passes through the score state into
//   the emit state, where the first result appears. Input stays blocked until the final
//   result transaction; the sum shift line is cleared as it drains, so the next view
//   starts from zero. cfg_wr_en/cfg_wr_data write cost_threshold; the user must write
//   it only while the block is idle, which the block itself does not enforce.
//   Reset clears all sums, the threshold and the controller.
`timescale 1ns / 1ps

module template_score_lane_accumulator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] response_lanes_0_7,
    input  logic [63:0] response_lanes_8_15,
    input  logic [63:0] response_lanes_16_23,
    input  logic [63:0] response_lanes_24_31,
    input  logic [63:0] response_lanes_32_39,
    input  logic [63:0] response_lanes_40_47,
    input  logic [63:0] response_lanes_48_55,
    input  logic [63:0] response_lanes_56_63,
    input  logic [7:0]  point_weight,
    input  logic        last_point,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  lane_index,
    output logic [31:0] raw_cost,
    output logic        lane_valid,
    output logic [63:0] valid_mask,
    output logic        last_lane
);
    import tsla_pkg::*;

    tsla_cmd_t              cmd;
    tsla_sts_t              sts;
    logic [RESP_FLAT_W-1:0] resp_flat;

    assign resp_flat = {response_lanes_56_63, response_lanes_48_55,
                        response_lanes_40_47, response_lanes_32_39,
                        response_lanes_24_31, response_lanes_16_23,
                        response_lanes_8_15,  response_lanes_0_7};

    tsla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .out_ready  (out_ready),
        .sts        (sts),
        .cmd        (cmd),
        .in_ready   (in_ready),
        .out_valid  (out_valid)
    );

    tsla_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .resp_flat    (resp_flat),
        .point_weight (point_weight),
        .lane_index   (lane_index),
        .raw_cost     (raw_cost),
        .lane_valid   (lane_valid),
        .valid_mask   (valid_mask),
        .last_lane    (last_lane)
    );

endmodule
